[sv/tilt_compensated_compass_core_macros.svh]
// assertion macros for the tilt compensated compass core
`ifndef TILT_COMPENSATED_COMPASS_CORE_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCC_CHK(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TCC_CHK_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tcc_pkg.sv]
// shared types, codes and constant tables of the tilt compensated compass
package tcc_pkg;

	localparam int TRIG_BITS  = 24;
	localparam int GUARD_BITS = 8;
	localparam int TABLE_BITS = 20;
	localparam int TABLE_LEN  = 24;
	localparam int CW         = 63;
	localparam int ZW         = 28;

	localparam logic [CW-1:0] MX_COARSE = 63'h0004_0000_0000_0000;
	localparam logic [CW-1:0] MX_FINE   = 63'h0400_0000_0000_0000;

	typedef logic [3:0] sel_t;

	// multiply selects
	localparam sel_t MUL_AY2  = 4'd0;
	localparam sel_t MUL_AZ2  = 4'd1;
	localparam sel_t MUL_AX2  = 4'd2;
	localparam sel_t MUL_FXCP = 4'd3;
	localparam sel_t MUL_FZSP = 4'd4;
	localparam sel_t MUL_FZCP = 4'd5;
	localparam sel_t MUL_FXSP = 4'd6;
	localparam sel_t MUL_USR  = 4'd7;
	localparam sel_t MUL_FYCR = 4'd8;

	// square root selects
	localparam sel_t SQ_S = 4'd0;
	localparam sel_t SQ_A = 4'd1;

	// divide selects
	localparam sel_t DIV_SINP = 4'd0;
	localparam sel_t DIV_COSP = 4'd1;
	localparam sel_t DIV_SINR = 4'd2;
	localparam sel_t DIV_COSR = 4'd3;

	// arctangent selects
	localparam sel_t ATN_PITCH = 4'd0;
	localparam sel_t ATN_ROLL  = 4'd1;
	localparam sel_t ATN_RAW   = 4'd2;
	localparam sel_t ATN_LVL   = 4'd3;

	// compass sectors
	localparam logic [3:0] SEC_0     = 4'd0;
	localparam logic [3:0] SEC_1     = 4'd1;
	localparam logic [3:0] SEC_2     = 4'd2;
	localparam logic [3:0] SEC_3     = 4'd3;
	localparam logic [3:0] SEC_4     = 4'd4;
	localparam logic [3:0] SEC_5     = 4'd5;
	localparam logic [3:0] SEC_6     = 4'd6;
	localparam logic [3:0] SEC_7     = 4'd7;
	localparam logic [3:0] NO_SECTOR = 4'd8;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_MUL,
		OP_ACC,
		OP_SQ_INIT,
		OP_SQ_STEP,
		OP_SQ_END,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_AT_INIT,
		OP_AT_NORM,
		OP_AT_ROT,
		OP_AT_END,
		OP_SECTOR,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_CHK,
		S_SQ_INIT,
		S_SQ_STEP,
		S_SQ_END,
		S_DIV_INIT,
		S_DIV_STEP,
		S_DIV_END,
		S_AT_INIT,
		S_AT_NORM,
		S_AT_ROT,
		S_AT_END,
		S_SECT,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t        op;
		sel_t       sel;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic zg;
		logic s_zero;
		logic norm_done;
	} status_t;

	// atan(2^-i) in degrees, 20 fraction bits
	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:    v = 28'sd47185920;
			5'd1:    v = 28'sd27855475;
			5'd2:    v = 28'sd14718068;
			5'd3:    v = 28'sd7471121;
			5'd4:    v = 28'sd3750058;
			5'd5:    v = 28'sd1876857;
			5'd6:    v = 28'sd938658;
			5'd7:    v = 28'sd469357;
			5'd8:    v = 28'sd234682;
			5'd9:    v = 28'sd117342;
			5'd10:   v = 28'sd58671;
			5'd11:   v = 28'sd29335;
			5'd12:   v = 28'sd14668;
			5'd13:   v = 28'sd7334;
			5'd14:   v = 28'sd3667;
			5'd15:   v = 28'sd1833;
			5'd16:   v = 28'sd917;
			5'd17:   v = 28'sd458;
			5'd18:   v = 28'sd229;
			5'd19:   v = 28'sd115;
			5'd20:   v = 28'sd57;
			5'd21:   v = 28'sd29;
			5'd22:   v = 28'sd14;
			5'd23:   v = 28'sd7;
			default: v = 28'sd0;
		endcase
		return v;
	endfunction

endpackage

[sv/tcc_sample_if.sv]
// input channel: one accelerometer and one magnetometer sample per beat
interface tcc_sample_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;
	logic signed [SAMPLE_BITS-1:0] field_x;
	logic signed [SAMPLE_BITS-1:0] field_y;
	logic signed [SAMPLE_BITS-1:0] field_z;

	modport source (output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
		output ready);
endinterface

[sv/tcc_result_if.sv]
// output channel: angles, sector and zero gravity flag per beat
interface tcc_result_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] pitch_angle;
	logic signed [13:0] roll_angle;
	logic signed [13:0] raw_heading;
	logic signed [13:0] level_heading;
	logic        [3:0]  sector;
	logic               zero_gravity;

	modport source (output valid, pitch_angle, roll_angle, raw_heading, level_heading,
		sector, zero_gravity, input ready);
	modport sink (input valid, pitch_angle, roll_angle, raw_heading, level_heading,
		sector, zero_gravity, output ready);
endinterface

[sv/tcc_ctrl.sv]
// sequencer of the compass datapath and owner of the channel handshakes
module tcc_ctrl #(
	parameter int SAMPLE_BITS  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tcc_pkg::status_t status,
	output tcc_pkg::cmd_t   cmd
);
	import tcc_pkg::*;

	localparam int RW    = SAMPLE_BITS + GUARD_BITS;
	localparam int QW    = TRIG_BITS + 1;
	localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	state_t     state_q, state_d;
	sel_t       sel_q, sel_d;
	logic [5:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic       emit_go;

	assign emit_go   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= MUL_AY2;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			cnt_q   <= cnt_d;
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MUL;
					sel_d   = MUL_AY2;
				end
			end
			S_MUL: state_d = S_ACC;
			S_ACC: begin
				if (sel_q == MUL_AX2) begin
					state_d = S_CHK;
				end else if (sel_q == MUL_FYCR) begin
					state_d = S_AT_INIT;
					sel_d   = ATN_RAW;
				end else begin
					state_d = S_MUL;
					sel_d   = sel_q + 4'd1;
				end
			end
			S_CHK: begin
				if (status.zg) begin
					state_d = S_MUL;
					sel_d   = MUL_FXCP;
				end else begin
					state_d = S_SQ_INIT;
					sel_d   = SQ_S;
				end
			end
			S_SQ_INIT: begin
				state_d = S_SQ_STEP;
				cnt_d   = '0;
			end
			S_SQ_STEP: begin
				if (cnt_q == 6'(RW - 1)) begin
					state_d = S_SQ_END;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_SQ_END: begin
				if (sel_q == SQ_S) begin
					state_d = S_SQ_INIT;
					sel_d   = SQ_A;
				end else begin
					state_d = S_DIV_INIT;
					sel_d   = DIV_SINP;
				end
			end
			S_DIV_INIT: begin
				state_d = S_DIV_STEP;
				cnt_d   = '0;
			end
			S_DIV_STEP: begin
				if (cnt_q == 6'(QW - 1)) begin
					state_d = S_DIV_END;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_DIV_END: begin
				// roll keeps its level defaults when the y-z projection is zero
				if (sel_q == DIV_COSR || (sel_q == DIV_COSP && status.s_zero)) begin
					state_d = S_AT_INIT;
					sel_d   = ATN_PITCH;
				end else begin
					state_d = S_DIV_INIT;
					sel_d   = sel_q + 4'd1;
				end
			end
			S_AT_INIT: state_d = S_AT_NORM;
			S_AT_NORM: begin
				if (status.norm_done) begin
					state_d = S_AT_ROT;
					cnt_d   = '0;
				end
			end
			S_AT_ROT: begin
				if (cnt_q == 6'(STEPS - 1)) begin
					state_d = S_AT_END;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_AT_END: begin
				if (sel_q == ATN_PITCH) begin
					state_d = S_AT_INIT;
					sel_d   = ATN_ROLL;
				end else if (sel_q == ATN_ROLL) begin
					state_d = S_MUL;
					sel_d   = MUL_FXCP;
				end else if (sel_q == ATN_RAW) begin
					state_d = S_AT_INIT;
					sel_d   = ATN_LVL;
				end else begin
					state_d = S_SECT;
				end
			end
			S_SECT: state_d = S_EMIT;
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd.sel  = sel_q;
		cmd.step = cnt_q[4:0];
		case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_IDLE;
			S_MUL:      cmd.op = OP_MUL;
			S_ACC:      cmd.op = OP_ACC;
			S_SQ_INIT:  cmd.op = OP_SQ_INIT;
			S_SQ_STEP:  cmd.op = OP_SQ_STEP;
			S_SQ_END:   cmd.op = OP_SQ_END;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV_STEP: cmd.op = OP_DIV_STEP;
			S_DIV_END:  cmd.op = OP_DIV_END;
			S_AT_INIT:  cmd.op = OP_AT_INIT;
			S_AT_NORM:  cmd.op = OP_AT_NORM;
			S_AT_ROT:   cmd.op = OP_AT_ROT;
			S_AT_END:   cmd.op = OP_AT_END;
			S_SECT:     cmd.op = OP_SECTOR;
			S_EMIT:     cmd.op = emit_go ? OP_OUT : OP_IDLE;
			default:    cmd.op = OP_IDLE;
		endcase
	end

endmodule

[sv/tcc_dp.sv]
// compass datapath: shared multiplier, root and divide units, cordic, sector
module tcc_dp #(
	parameter int SAMPLE_BITS     = 16,
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcc_pkg::cmd_t                 cmd,
	output tcc_pkg::status_t              status,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic signed [SAMPLE_BITS-1:0] field_x,
	input  logic signed [SAMPLE_BITS-1:0] field_y,
	input  logic signed [SAMPLE_BITS-1:0] field_z,
	output logic signed [13:0]            pitch_angle,
	output logic signed [13:0]            roll_angle,
	output logic signed [13:0]            raw_heading,
	output logic signed [13:0]            level_heading,
	output logic        [3:0]             sector,
	output logic                          zero_gravity
);
	import tcc_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int AF    = ANGLE_FRAC_BITS;
	localparam int SQW   = 2 * SB;
	localparam int RW    = SB + GUARD_BITS;
	localparam int RADW  = 2 * RW;
	localparam int NB    = RW;
	localparam int QW    = TRIG_BITS + 1;
	localparam int TW    = TRIG_BITS + 2;
	localparam int XW    = SB + 27;
	localparam int MAW   = XW - 12;
	localparam int PW    = MAW + TW;
	localparam int AW    = (AF + 8 > 14) ? AF + 8 : 14;
	localparam int RSH   = TABLE_BITS - AF;
	localparam int RND_I = 1 << (RSH - 1);
	localparam int LIM_I = 90 << AF;
	localparam int T22_I = (45 << AF) / 2;
	localparam int T67_I = (135 << AF) / 2;

	localparam logic [QW-1:0]        ONE  = QW'(1) << TRIG_BITS;
	localparam logic signed [ZW-1:0] LIMZ = ZW'(LIM_I);
	localparam logic signed [AW-1:0] LIMA = AW'(LIM_I);
	localparam logic signed [AW-1:0] T22  = AW'(T22_I);
	localparam logic signed [AW-1:0] T67  = AW'(T67_I);

	// |v| * 2^guard
	function automatic logic [NB-1:0] mag_guard(input logic signed [SB-1:0] v);
		logic signed [SB:0] e;
		logic        [SB:0] m;
		e = (SB+1)'(v);
		m = e[SB] ? (SB+1)'(-e) : (SB+1)'(e);
		return NB'({m, {GUARD_BITS{1'b0}}});
	endfunction

	logic signed [SB-1:0]  ax_q, ay_q, az_q, fx_q, fy_q, fz_q;
	logic                  zg_q;
	logic signed [PW-1:0]  prod_q;
	logic        [SQW-1:0] sqs_q, sqa_q;
	logic signed [XW-1:0]  xh_q, yh_q, u_q;
	logic signed [TW-1:0]  sinp_q, cosp_q, sinr_q, cosr_q;

	logic [RADW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q, s_q, a_q;

	logic [NB-1:0] den_q;
	logic [NB:0]   drem_q;
	logic [QW-1:0] quo_q;
	logic          dneg_q;

	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic                 spec_q;
	logic signed [AW-1:0] specv_q;

	logic signed [AW-1:0] pitch_q, roll_q, raw_q, lvl_q;
	logic        [3:0]    last_sector_q;

	// multiplier operands
	logic signed [MAW-1:0] ma;
	logic signed [TW-1:0]  mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.sel)
			MUL_AY2:  begin ma = MAW'(ay_q);        mb = TW'(ay_q);  end
			MUL_AZ2:  begin ma = MAW'(az_q);        mb = TW'(az_q);  end
			MUL_AX2:  begin ma = MAW'(ax_q);        mb = TW'(ax_q);  end
			MUL_FXCP: begin ma = MAW'(fx_q);        mb = cosp_q;     end
			MUL_FZSP: begin ma = MAW'(fz_q);        mb = sinp_q;     end
			MUL_FZCP: begin ma = MAW'(fz_q);        mb = cosp_q;     end
			MUL_FXSP: begin ma = MAW'(fx_q);        mb = sinp_q;     end
			MUL_USR:  begin ma = MAW'(u_q >>> 12);  mb = sinr_q;     end
			MUL_FYCR: begin ma = MAW'(fy_q);        mb = cosr_q;     end
			default:  begin ma = '0;                mb = '0;         end
		endcase
	end

	logic signed [PW-1:0] prod_sh;
	assign prod_sh = prod_q >>> 12;

	// square root step, two radicand bits per cycle
	logic [RW+3:0] rem_sh, trial;
	logic          sq_ge;
	assign rem_sh = {rem_q, rad_q[RADW-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign sq_ge  = (rem_sh >= trial);

	// restoring divide step
	logic          dv_ge;
	logic [NB:0]   dv_diff;
	logic [QW-1:0] quo_sat;
	assign dv_ge   = (drem_q >= {1'b0, den_q});
	assign dv_diff = dv_ge ? drem_q - {1'b0, den_q} : drem_q;
	assign quo_sat = (quo_q > ONE) ? ONE : quo_q;

	// divide operand selection
	logic [NB-1:0] dv_mag, dv_den;
	logic          dv_neg;
	always_comb begin
		case (cmd.sel)
			DIV_SINP: begin
				dv_mag = mag_guard(ax_q);
				dv_neg = !ax_q[SB-1] && (ax_q != '0);
				dv_den = a_q;
			end
			DIV_COSP: begin dv_mag = s_q; dv_neg = 1'b0; dv_den = a_q; end
			DIV_SINR: begin dv_mag = mag_guard(ay_q); dv_neg = ay_q[SB-1]; dv_den = s_q; end
			DIV_COSR: begin dv_mag = mag_guard(az_q); dv_neg = 1'b0; dv_den = s_q; end
			default:  begin dv_mag = '0; dv_neg = 1'b0; dv_den = a_q; end
		endcase
	end

	// arctangent operand selection
	logic signed [CW-1:0] an, ad;
	always_comb begin
		case (cmd.sel)
			ATN_PITCH: begin an = CW'(sinp_q); ad = CW'(cosp_q); end
			ATN_ROLL:  begin an = CW'(sinr_q); ad = CW'(cosr_q); end
			ATN_RAW:   begin an = CW'(fy_q);   ad = CW'(fx_q);   end
			ATN_LVL:   begin an = CW'(yh_q);   ad = CW'(xh_q);   end
			default:   begin an = '0;          ad = '0;          end
		endcase
	end

	// normalization and rotation
	logic [CW-1:0]        cy_abs, mx;
	logic signed [CW-1:0] sx, sy;
	logic signed [ZW-1:0] tab, z_rnd, z_sh, z_cl;
	assign cy_abs = cy_q[CW-1] ? CW'(-cy_q) : CW'(cy_q);
	assign mx     = (CW'(cx_q) > cy_abs) ? CW'(cx_q) : cy_abs;
	assign sx     = cx_q >>> cmd.step;
	assign sy     = cy_q >>> cmd.step;
	assign tab    = atan_tab(cmd.step);
	assign z_rnd  = cz_q + ZW'(RND_I);
	assign z_sh   = z_rnd >>> RSH;
	assign z_cl   = (z_sh > LIMZ) ? LIMZ : ((z_sh < -LIMZ) ? -LIMZ : z_sh);

	logic signed [AW-1:0] at_res;
	assign at_res = spec_q ? specv_q : AW'(z_cl);

	// sector from the quadrant of the level field and the heading
	logic [3:0] sec_d;
	logic       yh_pos, yh_neg, xh_pos, xh_neg;
	assign yh_neg = yh_q[XW-1];
	assign yh_pos = !yh_q[XW-1] && (yh_q != '0);
	assign xh_neg = xh_q[XW-1];
	assign xh_pos = !xh_q[XW-1] && (xh_q != '0);
	always_comb begin
		sec_d = last_sector_q;
		if (!yh_pos && !xh_pos) begin
			sec_d = (lvl_q < T22) ? SEC_1 : ((lvl_q < T67) ? SEC_2 : SEC_3);
		end else if (yh_pos && xh_neg) begin
			sec_d = (lvl_q < -T67) ? SEC_7 : ((lvl_q < -T22) ? SEC_0 : SEC_1);
		end else if (yh_pos && xh_pos) begin
			sec_d = (lvl_q < T22) ? SEC_5 : ((lvl_q < T67) ? SEC_6 : SEC_7);
		end else if (yh_neg && xh_pos) begin
			sec_d = (lvl_q < -T67) ? SEC_3 : ((lvl_q < -T22) ? SEC_4 : SEC_5);
		end
	end

	assign status.zg        = zg_q;
	assign status.s_zero    = (s_q == '0);
	assign status.norm_done = spec_q || (mx >= MX_FINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sector_q <= NO_SECTOR;
		end else if (cmd.op == OP_SECTOR) begin
			last_sector_q <= sec_d;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ax_q    <= accel_x;
				ay_q    <= accel_y;
				az_q    <= accel_z;
				fx_q    <= field_x;
				fy_q    <= field_y;
				fz_q    <= field_z;
				zg_q    <= (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
				sinp_q  <= '0;
				cosp_q  <= TW'(ONE);
				sinr_q  <= '0;
				cosr_q  <= TW'(ONE);
				pitch_q <= '0;
				roll_q  <= '0;
				s_q     <= '0;
			end
			OP_MUL: prod_q <= ma * mb;
			OP_ACC: begin
				case (cmd.sel)
					MUL_AY2:  sqs_q <= prod_q[SQW-1:0];
					MUL_AZ2:  sqs_q <= sqs_q + prod_q[SQW-1:0];
					MUL_AX2:  sqa_q <= sqs_q + prod_q[SQW-1:0];
					MUL_FXCP: xh_q  <= prod_q[XW-1:0];
					MUL_FZSP: xh_q  <= xh_q + prod_q[XW-1:0];
					MUL_FZCP: u_q   <= prod_q[XW-1:0];
					MUL_FXSP: u_q   <= u_q - prod_q[XW-1:0];
					MUL_USR:  yh_q  <= -prod_sh[XW-1:0];
					MUL_FYCR: yh_q  <= yh_q + prod_q[XW-1:0];
					default:  prod_q <= prod_q;
				endcase
			end
			OP_SQ_INIT: begin
				rad_q  <= {(cmd.sel == SQ_A) ? sqa_q : sqs_q, {(2*GUARD_BITS){1'b0}}};
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQ_STEP: begin
				rad_q  <= {rad_q[RADW-3:0], 2'b00};
				rem_q  <= (RW+2)'(sq_ge ? rem_sh - trial : rem_sh);
				root_q <= {root_q[RW-2:0], sq_ge};
			end
			OP_SQ_END: begin
				if (cmd.sel == SQ_A) begin
					a_q <= root_q;
				end else begin
					s_q <= root_q;
				end
			end
			OP_DIV_INIT: begin
				drem_q <= {1'b0, dv_mag};
				den_q  <= dv_den;
				dneg_q <= dv_neg;
				quo_q  <= '0;
			end
			OP_DIV_STEP: begin
				drem_q <= {dv_diff[NB-1:0], 1'b0};
				quo_q  <= {quo_q[QW-2:0], dv_ge};
			end
			OP_DIV_END: begin
				case (cmd.sel)
					DIV_SINP: sinp_q <= dneg_q ? -TW'(quo_sat) : TW'(quo_sat);
					DIV_COSP: cosp_q <= dneg_q ? -TW'(quo_sat) : TW'(quo_sat);
					DIV_SINR: sinr_q <= dneg_q ? -TW'(quo_sat) : TW'(quo_sat);
					default:  cosr_q <= dneg_q ? -TW'(quo_sat) : TW'(quo_sat);
				endcase
			end
			OP_AT_INIT: begin
				cz_q <= '0;
				if (ad == '0) begin
					spec_q  <= 1'b1;
					specv_q <= an[CW-1] ? -LIMA : ((an == '0) ? '0 : LIMA);
				end else if (an == '0) begin
					spec_q  <= 1'b1;
					specv_q <= '0;
				end else begin
					spec_q  <= 1'b0;
					specv_q <= '0;
				end
				// fold the left half plane onto the right
				cx_q <= ad[CW-1] ? -ad : ad;
				cy_q <= ad[CW-1] ? -an : an;
			end
			OP_AT_NORM: begin
				if (!spec_q) begin
					if (mx < MX_COARSE) begin
						cx_q <= cx_q <<< 8;
						cy_q <= cy_q <<< 8;
					end else if (mx < MX_FINE) begin
						cx_q <= cx_q <<< 1;
						cy_q <= cy_q <<< 1;
					end
				end
			end
			OP_AT_ROT: begin
				if (!cy_q[CW-1] && (cy_q != '0)) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + tab;
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - tab;
				end
			end
			OP_AT_END: begin
				case (cmd.sel)
					ATN_PITCH: pitch_q <= at_res;
					ATN_ROLL:  roll_q  <= at_res;
					ATN_RAW:   raw_q   <= at_res;
					default:   lvl_q   <= at_res;
				endcase
			end
			OP_OUT: begin
				pitch_angle   <= pitch_q[13:0];
				roll_angle    <= roll_q[13:0];
				raw_heading   <= raw_q[13:0];
				level_heading <= lvl_q[13:0];
				sector        <= last_sector_q;
				zero_gravity  <= zg_q;
			end
			default: prod_q <= prod_q;
		endcase
	end

endmodule

[sv/tilt_compensated_compass_core.sv]
// Tilt compensated compass: one accelerometer and magnetometer sample pair per input
// beat gives pitch, roll, raw and level heading (signed, 1/2^ANGLE_FRAC_BITS degree),
// a compass sector and a zero gravity flag in one output beat. Items are processed one
// at a time; a finished result waits in the output register while the next sample is
// taken. An item runs the shared multiplies, two integer square roots, up to four divides
// and four arctangents on the shared cordic unit, each with normalization and then
// CORDIC_STEPS rotations (at most TABLE_LEN). All-zero acceleration skips roots,
// divides and two arctangents; a zero y-z acceleration skips the two roll divides.
`include "tilt_compensated_compass_core_macros.svh"

module tilt_compensated_compass_core #(
	parameter int SAMPLE_BITS     = 16,
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tcc_sample_if.sink   samples,
	tcc_result_if.source results
);
	import tcc_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: walks multiply, root, divide and cordic phases
	tcc_ctrl #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: holds the sample, working values, sector state and output register
	tcc_dp #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.accel_x       (samples.accel_x),
		.accel_y       (samples.accel_y),
		.accel_z       (samples.accel_z),
		.field_x       (samples.field_x),
		.field_y       (samples.field_y),
		.field_z       (samples.field_z),
		.pitch_angle   (results.pitch_angle),
		.roll_angle    (results.roll_angle),
		.raw_heading   (results.raw_heading),
		.level_heading (results.level_heading),
		.sector        (results.sector),
		.zero_gravity  (results.zero_gravity)
	);

	// one sample beat at a time
	`TCC_CHK_NEXT(a_one_item, clk, arst_n, samples.valid && samples.ready, !samples.ready, "sample taken while busy")
	// sector is a compass point or the none-lit code
	`TCC_CHK(a_sector_range, clk, arst_n, results.valid, results.sector <= NO_SECTOR, "sector out of range")
	// zero gravity forces a level attitude
	`TCC_CHK(a_zg_level, clk, arst_n, results.valid && results.zero_gravity, (results.pitch_angle == 14'sd0) && (results.roll_angle == 14'sd0), "tilt with zero gravity")

endmodule

[sim/tb_tilt_compensated_compass_core.sv]
// self-checking testbench for the tilt compensated compass core
module tb_tilt_compensated_compass_core;
	import tcc_pkg::*;

	localparam int  FRAC      = 6;
	localparam int  STEPS     = 16;
	localparam longint LIM    = 64'sd90 <<< FRAC;
	localparam longint T22    = (64'sd45 <<< FRAC) / 2;
	localparam longint T67    = (64'sd135 <<< FRAC) / 2;
	localparam int  N_RANDOM  = 700;
	localparam int  IDLE_LIMIT = 10000;
	localparam int  HOLD_CYCLES = 2000;

	typedef struct {
		logic signed [13:0] pitch;
		logic signed [13:0] roll;
		logic signed [13:0] raw;
		logic signed [13:0] lvl;
		logic [3:0]         sector;
		logic               zg;
	} heading_t;

	typedef struct {
		logic signed [15:0] ax, ay, az, fx, fy, fz;
		bit                 known;
		heading_t           res;
	} sample_row_t;

	logic clk;
	logic arst_n;

	tcc_sample_if #(.SAMPLE_BITS(16)) sif ();
	tcc_result_if rif ();

	tilt_compensated_compass_core #(
		.SAMPLE_BITS(16),
		.ANGLE_FRAC_BITS(FRAC),
		.CORDIC_STEPS(STEPS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sif.sink),
		.results(rif.source)
	);

	// model state and checking bookkeeping
	logic [3:0]  held_sector;
	heading_t    headings_due[$];
	sample_row_t sample_tab[$];
	int          n_errors = 0;
	int          n_sent;
	int          n_got = 0;
	int          n_zg;
	int          idle_cycles = 0;
	logic [8:0]  sectors_seen = '0;
	bit          stim_done;

	// clock, period 2
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	//--------------------------------------------------------------------
	// predictor of the block, 64-bit integer arithmetic
	//--------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// signed q24 quotient, clipped to +-1
	function automatic longint trig_ratio(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag << TRIG_BITS) / den;
		if (q > (64'd1 << TRIG_BITS))
			q = 64'd1 << TRIG_BITS;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// vectoring cordic arctangent of n/d, folded to +-90 degrees
	function automatic longint arctan_deg(input longint n, input longint d);
		longint x, y, z, t, mx, ay_abs;
		z = 0;
		if (d == 0)
			return (n > 0) ? LIM : ((n < 0) ? -LIM : 0);
		if (n == 0)
			return 0;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		x = d;
		y = n;
		ay_abs = (y < 0) ? -y : y;
		mx = (x > ay_abs) ? x : ay_abs;
		while (mx >= (64'sd1 <<< 60)) begin
			x = x >>> 1;
			y = y >>> 1;
			mx = mx >>> 1;
		end
		while (mx < (64'sd1 <<< 58)) begin
			x = x * 2;
			y = y * 2;
			mx = mx * 2;
		end
		for (int i = 0; i < STEPS; i++) begin
			t = x;
			if (y > 0) begin
				x += y >>> i;
				y -= t >>> i;
				z += longint'(atan_tab(i[4:0]));
			end else begin
				x -= y >>> i;
				y += t >>> i;
				z -= longint'(atan_tab(i[4:0]));
			end
		end
		z = (z + (64'sd1 <<< (TABLE_BITS - FRAC - 1))) >>> (TABLE_BITS - FRAC);
		if (z > LIM)
			z = LIM;
		if (z < -LIM)
			z = -LIM;
		return z;
	endfunction

	// full heading computation; updates the held sector
	function automatic heading_t compass_predict(input sample_row_t s);
		heading_t r;
		longint ax, ay, az, fx, fy, fz;
		longint sinp, cosp, sinr, cosr, pitch, roll, xh, yh, u, lvl, raw;
		longint unsigned sq_s, sq_a, rs, ra;
		ax = s.ax; ay = s.ay; az = s.az;
		fx = s.fx; fy = s.fy; fz = s.fz;
		sinp = 0; cosp = 64'sd1 <<< TRIG_BITS;
		sinr = 0; cosr = 64'sd1 <<< TRIG_BITS;
		pitch = 0; roll = 0;
		sq_s = ay * ay + az * az;
		sq_a = sq_s + ax * ax;
		if (sq_a != 0) begin
			rs = int_sqrt(sq_s << (2 * GUARD_BITS));
			ra = int_sqrt(sq_a << (2 * GUARD_BITS));
			if (ra == 0)
				ra = 1;
			sinp = trig_ratio(-ax * 256, ra);
			cosp = trig_ratio(longint'(rs), ra);
			if (rs != 0) begin
				sinr = trig_ratio(ay * 256, rs);
				cosr = trig_ratio(((az < 0) ? -az : az) * 256, rs);
			end
			pitch = arctan_deg(sinp, cosp);
			roll = arctan_deg(sinr, cosr);
		end
		// rotate field into the horizontal plane
		xh = fx * cosp + fz * sinp;
		u = fz * cosp - fx * sinp;
		yh = fy * cosr - (((u >>> 12) * sinr) >>> 12);
		lvl = arctan_deg(yh, xh);
		raw = arctan_deg(fy, fx);
		if (yh <= 0 && xh <= 0)
			held_sector = (lvl < T22) ? SEC_1 : ((lvl < T67) ? SEC_2 : SEC_3);
		else if (yh > 0 && xh < 0)
			held_sector = (lvl < -T67) ? SEC_7 : ((lvl < -T22) ? SEC_0 : SEC_1);
		else if (yh > 0 && xh > 0)
			held_sector = (lvl < T22) ? SEC_5 : ((lvl < T67) ? SEC_6 : SEC_7);
		else if (yh < 0 && xh > 0)
			held_sector = (lvl < -T67) ? SEC_3 : ((lvl < -T22) ? SEC_4 : SEC_5);
		// the two axis cases fall through and keep the held sector
		r.pitch = pitch[13:0];
		r.roll = roll[13:0];
		r.raw = raw[13:0];
		r.lvl = lvl[13:0];
		r.sector = held_sector;
		r.zg = (sq_a == 0);
		return r;
	endfunction

	//--------------------------------------------------------------------
	// stimulus rows
	//--------------------------------------------------------------------
	task automatic add_row(input int ax, ay, az, fx, fy, fz, input bit known = 0,
		input int p = 0, input int rl = 0, input int rw = 0, input int lv = 0,
		input int sec = 0, input int zg = 0);
		sample_row_t s;
		s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
		s.fx = 16'(fx); s.fy = 16'(fy); s.fz = 16'(fz);
		s.known = known;
		s.res.pitch = 14'(p); s.res.roll = 14'(rl); s.res.raw = 14'(rw);
		s.res.lvl = 14'(lv);
		s.res.sector = 4'(sec); s.res.zg = zg[0];
		sample_tab.push_back(s);
	endtask

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic logic signed [15:0] near(input int centre, input int spread);
		return 16'(centre + $urandom_range(0, 2 * spread) - spread);
	endfunction

	function automatic sample_row_t random_row();
		sample_row_t s;
		int pick;
		pick = $urandom_range(0, 9);
		s.known = 0;
		s.fx = near(0, 3000); s.fy = near(0, 3000); s.fz = near(0, 3000);
		if (pick <= 5) begin
			// device near level, gravity mostly on z
			s.ax = near(0, 6000);
			s.ay = near(0, 6000);
			s.az = near(($urandom_range(0, 1) != 0) ? 16384 : -16384, 4000);
		end else if (pick <= 7) begin
			s.ax = rnd16(); s.ay = rnd16(); s.az = rnd16();
			s.fx = rnd16(); s.fy = rnd16(); s.fz = rnd16();
		end else if (pick == 8) begin
			// free fall
			s.ax = 0; s.ay = 0; s.az = 0;
			if ($urandom_range(0, 2) == 0)
				s.fx = 0;
			else if ($urandom_range(0, 1) == 0)
				s.fy = 0;
		end else begin
			// axis cases: gravity only or mostly on x, and a field x or y component at zero
			s.ax = rnd16();
			s.ay = ($urandom_range(0, 1) != 0) ? 16'sd0 : near(0, 200);
			s.az = ($urandom_range(0, 1) != 0) ? 16'sd0 : near(0, 200);
			if ($urandom_range(0, 1) != 0)
				s.fx = 0;
			else
				s.fy = 0;
		end
		return s;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, n_got, got, want);
		n_errors++;
	endtask

	//--------------------------------------------------------------------
	// result side: stall pattern, long hold-off, checking
	//--------------------------------------------------------------------
	initial begin
		int hold_left;
		int phase_cyc;
		int phase;
		bit hold_used;
		hold_left = 0;
		phase_cyc = 0;
		phase = 0;
		hold_used = 0;
		rif.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_used && n_got >= 150) begin
				hold_used = 1;
				hold_left = HOLD_CYCLES;
			end
			phase_cyc++;
			if (phase_cyc >= 300) begin
				phase_cyc = 0;
				phase = (phase + 1) % 3;
			end
			if (hold_left > 0) begin
				hold_left--;
				rif.ready = 1'b0;
			end else begin
				case (phase)
					0: rif.ready = 1'b1;
					1: rif.ready = ($urandom_range(0, 1) != 0);
					default: rif.ready = ((phase_cyc % 11) > 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		heading_t want;
		if (arst_n && rif.valid && rif.ready) begin
			if (headings_due.size() == 0) begin
				$display("unexpected result beat, nothing outstanding");
				n_errors++;
			end else begin
				want = headings_due.pop_front();
				if (rif.pitch_angle !== want.pitch)
					report("pitch_angle", rif.pitch_angle, want.pitch);
				if (rif.roll_angle !== want.roll)
					report("roll_angle", rif.roll_angle, want.roll);
				if (rif.raw_heading !== want.raw)
					report("raw_heading", rif.raw_heading, want.raw);
				if (rif.level_heading !== want.lvl)
					report("level_heading", rif.level_heading, want.lvl);
				if (rif.sector !== want.sector)
					report("sector", rif.sector, want.sector);
				if (rif.zero_gravity !== want.zg)
					report("zero_gravity", rif.zero_gravity, want.zg);
				if (rif.sector <= NO_SECTOR)
					sectors_seen[rif.sector] = 1'b1;
			end
			n_got++;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((sif.valid && sif.ready) || (rif.valid && rif.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, headings_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// sample side and run control
	//--------------------------------------------------------------------
	initial begin
		sample_row_t s;
		heading_t    predicted;
		int          burst_left;
		int          gap;
		int          n_rows;
		int          wait_cyc;

		arst_n = 1'b0;
		sif.valid = 1'b0;
		sif.accel_x = '0; sif.accel_y = '0; sif.accel_z = '0;
		sif.field_x = '0; sif.field_y = '0; sif.field_z = '0;
		held_sector = NO_SECTOR;
		n_sent = 0; n_zg = 0;
		stim_done = 0;

		// free fall rows with obvious answers; sector starts at 1 from the origin
		add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, SEC_1, 1);
		// heading divide by zero, positive numerator; yh>0 on xh=0 keeps the sector
		add_row(0, 0, 0, 0, 100, 0, 1, 0, 0, 5760, 5760, SEC_1, 1);
		add_row(0, 0, 0, 0, -100, 0, 1, 0, 0, -5760, -5760, SEC_1, 1);
		// yh=0 with xh>0 keeps the sector
		add_row(0, 0, 0, 5, 0, 0, 1, 0, 0, 0, 0, SEC_1, 1);
		// gravity on x only: roll ratio 0/0, pitch at the limits
		add_row(1000, 0, 0, 300, 200, 100);
		add_row(-32768, 0, 0, 300, -200, 100);
		add_row(32767, 32767, 32767, 32767, 32767, 32767);
		add_row(-32768, -32768, -32768, -32768, -32768, -32768);
		add_row(0, 0, -16384, -32768, 32767, -32768);
		// level attitude, a field direction in each sector band
		add_row(0, 0, 16384, -100, -10, 0);
		add_row(0, 0, 16384, -100, -100, 0);
		add_row(0, 0, 16384, -10, -100, 0);
		add_row(0, 0, 16384, -100, 10, 0);
		add_row(0, 0, 16384, -100, 100, 0);
		add_row(0, 0, 16384, -10, 100, 0);
		add_row(0, 0, 16384, 100, 10, 0);
		add_row(0, 0, 16384, 100, 100, 0);
		add_row(0, 0, 16384, 10, 100, 0);
		add_row(0, 0, 16384, 100, -10, 0);
		add_row(0, 0, 16384, 100, -100, 0);
		add_row(0, 0, 16384, 10, -100, 0);
		// tilted device and a steep roll
		add_row(5000, -3000, 15000, 1200, -800, 400);
		add_row(-200, 16000, 100, -500, 900, -1500);
		n_rows = sample_tab.size();
		for (int i = 0; i < N_RANDOM; i++)
			sample_tab.push_back(random_row());

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		burst_left = $urandom_range(1, 30);
		for (int i = 0; i < sample_tab.size(); i++) begin
			s = sample_tab[i];
			@(negedge clk);
			sif.valid = 1'b1;
			sif.accel_x = s.ax; sif.accel_y = s.ay; sif.accel_z = s.az;
			sif.field_x = s.fx; sif.field_y = s.fy; sif.field_z = s.fz;
			@(posedge clk);
			while (!sif.ready)
				@(posedge clk);
			// beat taken: the predictor always runs so the held sector tracks
			predicted = compass_predict(s);
			headings_due.push_back(s.known ? s.res : predicted);
			n_sent++;
			if (predicted.zg)
				n_zg++;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap = $urandom_range(0, 20);
				if (gap > 0) begin
					@(negedge clk);
					sif.valid = 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
		@(negedge clk);
		sif.valid = 1'b0;
		stim_done = 1;

		while (headings_due.size() != 0)
			@(posedge clk);
		// drain: the block should stay quiet once everything is in
		wait_cyc = 0;
		while (wait_cyc < 400) begin
			@(posedge clk);
			wait_cyc++;
		end

		$display("%0d sample beats (%0d directed, %0d free fall), %0d results checked",
			n_sent, n_rows, n_zg, n_got);
		$display("sectors seen (bit per code, 8 = none): %b, mismatches: %0d",
			sectors_seen, n_errors);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
